// ===== design/ihex_pkg.sv =====
package ihex_pkg;

    localparam int CHAR_W   = 8;
    localparam int ADDR_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    // address, data, type, count, status packed, then padded to whole bytes
    localparam int M_FIELDS_W = ADDR_W + 3 * BYTE_W + STATUS_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [CHAR_W-1:0] START_CODE = 8'h3A;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_START = 3'd1,
        ST_BAD_HEX   = 3'd2,
        ST_TRUNCATED = 3'd3,
        ST_CHECKSUM  = 3'd4
    } status_t;

    typedef enum logic {
        KIND_DATA   = 1'b0,
        KIND_STATUS = 1'b1
    } result_kind_t;

    typedef struct packed {
        logic       bad;
        logic [3:0] value;
    } nibble_t;

    function automatic nibble_t hex_nibble(input logic [CHAR_W-1:0] c);
        nibble_t n;
        n.bad   = 1'b0;
        n.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            n.value = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            n.value = c[3:0] + 4'd9;
        end else begin
            n.bad = 1'b1;
        end
        return n;
    endfunction

endpackage

// ===== design/intel_hex_record_parser.sv =====
// Intel HEX record parser. One ASCII character enters per transaction on the
// s_ side, with s_tlast on the line's last character; a new character is
// taken every cycle while the result register is free or being drained, so
// the block sustains one character per clock while it is not stalled. Each
// decoded data byte leaves as a result with m_tuser = 0 and its wrapped
// address; the line's last character yields one status result (m_tuser = 1):
// ok, bad start code, bad hex digit, truncated line or checksum mismatch.
// The checksum covers count, both address bytes, type and data modulo 256;
// characters after the checksum are ignored, and the first error on a line
// wins. A data byte completed on the last character is not emitted.
module intel_hex_record_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ihex_pkg::CHAR_W-1:0]   s_tdata,  // [7:0] character
    input  logic                          s_tlast,  // line_end
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [15:0] byte_address, [23:16] data_value, [31:24] record_kind,
    // [39:32] length_field, [42:40] status, rest zero
    output logic [ihex_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tuser   // kind
);
    import ihex_pkg::*;

    typedef enum logic [2:0] {
        PH_START,
        PH_HEADER,
        PH_DATA,
        PH_CHECK,
        PH_DONE,
        PH_FAULT
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [3:0]          high_nib_reg, high_nib_next;
    logic                digit_pos_reg, digit_pos_next;
    logic [BYTE_W-1:0]   count_reg, count_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [BYTE_W-1:0]   type_reg, type_next;
    logic [BYTE_W-1:0]   seen_reg, seen_next;
    logic [BYTE_W-1:0]   sum_reg, sum_next;
    status_t             err_reg, err_next;

    logic                m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                m_tuser_reg, m_tuser_next;

    logic                accept;
    logic                emit;
    logic [ADDR_W-1:0]   emit_addr;
    logic [BYTE_W-1:0]   byte_val;
    nibble_t             nib;
    status_t             line_status;
    logic [M_FIELDS_W-1:0] fields;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign nib      = hex_nibble(s_tdata);
    assign byte_val = {high_nib_reg, nib.value};

    always_comb begin
        phase_next     = phase_reg;
        high_nib_next  = high_nib_reg;
        digit_pos_next = digit_pos_reg;
        count_next     = count_reg;
        addr_next      = addr_reg;
        type_next      = type_reg;
        seen_next      = seen_reg;
        sum_next       = sum_reg;
        err_next       = err_reg;
        emit           = 1'b0;
        emit_addr      = addr_reg + ADDR_W'(seen_reg);

        case (phase_reg)
            PH_START: begin
                if (s_tdata == START_CODE) begin
                    phase_next = PH_HEADER;
                end else begin
                    err_next   = ST_BAD_START;
                    phase_next = PH_FAULT;
                end
            end
            PH_HEADER, PH_DATA, PH_CHECK: begin
                if (nib.bad) begin
                    err_next   = ST_BAD_HEX;
                    phase_next = PH_FAULT;
                end else if (!digit_pos_reg) begin
                    high_nib_next  = nib.value;
                    digit_pos_next = 1'b1;
                end else begin
                    digit_pos_next = 1'b0;
                    sum_next       = sum_reg + byte_val;
                    case (phase_reg)
                        PH_HEADER: begin
                            case (seen_reg[1:0])
                                2'd0:    count_next = byte_val;
                                2'd1:    addr_next  = {byte_val, 8'h00};
                                2'd2:    addr_next  = {addr_reg[15:8], byte_val};
                                default: type_next  = byte_val;
                            endcase
                            seen_next = seen_reg + 8'd1;
                            if (seen_reg == 8'd3) begin
                                seen_next  = '0;
                                phase_next = (count_reg == '0) ? PH_CHECK : PH_DATA;
                            end
                        end
                        PH_DATA: begin
                            emit      = 1'b1;
                            seen_next = seen_reg + 8'd1;
                            if (seen_next >= count_reg) phase_next = PH_CHECK;
                        end
                        default: begin
                            if (sum_next != '0) err_next = ST_CHECKSUM;
                            phase_next = PH_DONE;
                        end
                    endcase
                end
            end
            default: ;
        endcase

        if (err_next != ST_OK)       line_status = err_next;
        else if (phase_next == PH_DONE) line_status = ST_OK;
        else                          line_status = ST_TRUNCATED;

        if (s_tlast) begin
            m_tuser_next = KIND_STATUS;
            fields = {line_status, count_next, type_next, {BYTE_W{1'b0}}, addr_next};
        end else begin
            m_tuser_next = KIND_DATA;
            fields = {ST_OK, count_next, type_next, byte_val, emit_addr};
        end
        m_tdata_next = M_TDATA_W'(fields);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_START;
            high_nib_reg  <= '0;
            digit_pos_reg <= 1'b0;
            count_reg     <= '0;
            addr_reg      <= '0;
            type_reg      <= '0;
            seen_reg      <= '0;
            sum_reg       <= '0;
            err_reg       <= ST_OK;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                if (s_tlast) begin
                    // line done: back to the reset condition for the next record
                    phase_reg     <= PH_START;
                    high_nib_reg  <= '0;
                    digit_pos_reg <= 1'b0;
                    count_reg     <= '0;
                    addr_reg      <= '0;
                    type_reg      <= '0;
                    seen_reg      <= '0;
                    sum_reg       <= '0;
                    err_reg       <= ST_OK;
                end else begin
                    phase_reg     <= phase_next;
                    high_nib_reg  <= high_nib_next;
                    digit_pos_reg <= digit_pos_next;
                    count_reg     <= count_next;
                    addr_reg      <= addr_next;
                    type_reg      <= type_next;
                    seen_reg      <= seen_next;
                    sum_reg       <= sum_next;
                    err_reg       <= err_next;
                end
            end
            if (accept && (s_tlast || emit)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && (s_tlast || emit)) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ihex_pkg::*;

    localparam int ITEMS       = 1700;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        result_kind_t      kind;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] rtype;
        logic [BYTE_W-1:0] len;
        status_t           status;
    } hex_result_t;

    typedef enum logic [2:0] {
        AWAIT_COLON,
        IN_HEADER,
        IN_DATA,
        IN_CSUM,
        LINE_DONE,
        LINE_BAD
    } line_phase_t;

    // typed rows carry the status transaction that ends the line
    typedef struct {
        string      text;
        bit         typed;
        status_t    st;
        logic [15:0] addr;
        logic [7:0] rtype;
        logic [7:0] len;
    } line_case_t;

    line_case_t dir_tab[11] = '{
        '{":00000001FF",     1'b1, ST_OK,        16'h0000, 8'h01, 8'h00},
        '{"\377",            1'b1, ST_BAD_START, 16'h0000, 8'h00, 8'h00},
        '{":0G",             1'b1, ST_BAD_HEX,   16'h0000, 8'h00, 8'h00},
        '{":",               1'b1, ST_TRUNCATED, 16'h0000, 8'h00, 8'h00},
        '{":00000001FE",     1'b1, ST_CHECKSUM,  16'h0000, 8'h01, 8'h00},
        '{":0100000041",     1'b1, ST_TRUNCATED, 16'h0000, 8'h00, 8'h01},
        '{":0100000041BE",   1'b0, ST_OK,        16'h0000, 8'h00, 8'h00},
        '{":02FFFF00AA5501", 1'b0, ST_OK,        16'h0000, 8'h00, 8'h00},
        '{":01abcd00ff88",   1'b0, ST_OK,        16'h0000, 8'h00, 8'h00},
        '{":00000001FFxyz",  1'b0, ST_OK,        16'h0000, 8'h00, 8'h00},
        '{":01000000Z1",     1'b0, ST_OK,        16'h0000, 8'h00, 8'h00}
    };

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [CHAR_W-1:0]    s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    intel_hex_record_parser u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 aclk = ~aclk;

    // line parser state
    line_phase_t lp;
    logic [3:0]  hi_nib;
    logic        odd_digit;
    logic [7:0]  cnt_q;
    logic [15:0] addr_q;
    logic [7:0]  type_q;
    logic [7:0]  nb_q;
    logic [7:0]  sum_q;
    status_t     err_q;

    hex_result_t decoded_q[$];
    logic [7:0]  line_buf[$];

    int  errors;
    int  chars_sent;
    int  lines_sent;
    int  results_seen;
    int  bytes_seen;
    int  status_tally[5];
    bit  calm;
    bit  hold_off;
    bit  held;

    function automatic bit hex_digit(input logic [7:0] c, output logic [3:0] v);
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
        else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
        else return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    function automatic void append_char(input logic [7:0] c);
        line_buf.insert(line_buf.size(), c);
    endfunction

    function automatic void put_byte(input logic [7:0] b);
        append_char(hex_char(b[7:4]));
        append_char(hex_char(b[3:0]));
    endfunction

    function automatic string show(input hex_result_t r);
        return $sformatf("kind=%0d addr=%h data=%h type=%h len=%h status=%0d",
                         r.kind, r.addr, r.data, r.rtype, r.len, r.status);
    endfunction

    task automatic line_clear();
        lp        = AWAIT_COLON;
        hi_nib    = 4'd0;
        odd_digit = 1'b0;
        cnt_q     = 8'd0;
        addr_q    = 16'd0;
        type_q    = 8'd0;
        nb_q      = 8'd0;
        sum_q     = 8'd0;
        err_q     = ST_OK;
    endtask

    task automatic decode_char(input logic [7:0] c, input bit last,
                               output bit have, output hex_result_t res);
        logic [3:0]  v;
        logic [7:0]  b;
        logic [15:0] at;
        bit          emit;
        status_t     st;
        have = 1'b0;
        emit = 1'b0;
        b    = 8'd0;
        at   = 16'd0;
        res  = '0;
        case (lp)
            AWAIT_COLON: begin
                if (c == START_CODE) begin
                    line_clear();
                    lp = IN_HEADER;
                end else begin
                    err_q = ST_BAD_START;
                    lp    = LINE_BAD;
                end
            end
            IN_HEADER, IN_DATA, IN_CSUM: begin
                if (!hex_digit(c, v)) begin
                    err_q = ST_BAD_HEX;
                    lp    = LINE_BAD;
                end else if (!odd_digit) begin
                    hi_nib    = v;
                    odd_digit = 1'b1;
                end else begin
                    odd_digit = 1'b0;
                    b         = {hi_nib, v};
                    sum_q     = sum_q + b;
                    if (lp == IN_HEADER) begin
                        case (nb_q)
                            8'd0:    cnt_q = b;
                            8'd1:    addr_q = {b, 8'h00};
                            8'd2:    addr_q[7:0] = b;
                            default: type_q = b;
                        endcase
                        nb_q = nb_q + 8'd1;
                        if (nb_q >= 8'd4) begin
                            nb_q = 8'd0;
                            lp   = (cnt_q == 8'd0) ? IN_CSUM : IN_DATA;
                        end
                    end else if (lp == IN_DATA) begin
                        emit = 1'b1;
                        at   = addr_q + 16'(nb_q);
                        nb_q = nb_q + 8'd1;
                        if (nb_q >= cnt_q) lp = IN_CSUM;
                    end else begin
                        // sum includes the checksum byte itself
                        if (sum_q != 8'd0) err_q = ST_CHECKSUM;
                        lp = LINE_DONE;
                    end
                end
            end
            default: ;
        endcase

        if (last) begin
            if (err_q != ST_OK) st = err_q;
            else if (lp == LINE_DONE) st = ST_OK;
            else st = ST_TRUNCATED;
            have = 1'b1;
            res  = '{kind: KIND_STATUS, addr: addr_q, data: 8'd0, rtype: type_q,
                     len: cnt_q, status: st};
            status_tally[int'(st)]++;
            line_clear();
        end else if (emit) begin
            have = 1'b1;
            res  = '{kind: KIND_DATA, addr: at, data: b, rtype: type_q,
                     len: cnt_q, status: ST_OK};
        end
    endtask

    task automatic send_line(input bit typed, input hex_result_t want);
        bit          have;
        hex_result_t res;
        for (int i = 0; i < line_buf.size(); i++) begin
            while (!calm && $urandom_range(0, 99) < 24) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= line_buf[i];
            s_tlast  <= (i == line_buf.size() - 1);
            do @(posedge aclk); while (!s_tready);
            chars_sent++;
            decode_char(line_buf[i], i == line_buf.size() - 1, have, res);
            if (have) begin
                decoded_q.insert(decoded_q.size(),
                                 (typed && res.kind == KIND_STATUS) ? want : res);
            end
        end
        lines_sent++;
    endtask

    // mostly a record line, some with a single fault, some junk
    task automatic build_record();
        logic [7:0]  cnt;
        logic [7:0]  rtype;
        logic [7:0]  b;
        logic [7:0]  sum;
        logic [15:0] at;
        logic [3:0]  v;
        int          pick;
        int          k;
        line_buf.delete();
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 6)) append_char(8'($urandom));
            return;
        end
        cnt   = ($urandom_range(0, 49) == 0) ? 8'($urandom_range(17, 255))
                                             : 8'($urandom_range(0, 16));
        at    = 16'($urandom);
        rtype = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
        pick  = $urandom_range(0, 99);
        append_char(START_CODE);
        sum = cnt + at[15:8] + at[7:0] + rtype;
        put_byte(cnt);
        put_byte(at[15:8]);
        put_byte(at[7:0]);
        put_byte(rtype);
        repeat (cnt) begin
            b   = 8'($urandom);
            sum = sum + b;
            put_byte(b);
        end
        // any nonzero offset breaks the checksum
        put_byte(8'(8'd0 - sum) + ((pick >= 62 && pick < 70) ? 8'($urandom_range(1, 255))
                                                             : 8'd0));
        if (pick >= 70 && pick < 78) begin
            k = $urandom_range(1, line_buf.size() - 1);
            while (line_buf.size() > k) void'(line_buf.pop_back());
        end else if (pick >= 78 && pick < 86) begin
            k = $urandom_range(1, line_buf.size() - 1);
            do line_buf[k] = 8'($urandom); while (hex_digit(line_buf[k], v));
        end else if (pick >= 86 && pick < 93) begin
            repeat ($urandom_range(1, 4)) append_char(8'($urandom));
        end else if (pick >= 93) begin
            do line_buf[0] = 8'($urandom); while (line_buf[0] == START_CODE);
        end
    endtask

    task automatic flag_mismatch(input string why, input hex_result_t want,
                                 input hex_result_t got);
        errors++;
        if (errors <= 10) begin
            $display("[%0t] %s", $realtime, why);
            $display("    expected %s", show(want));
            $display("    actual   %s", show(got));
        end
    endtask

    always @(posedge aclk) begin
        hex_result_t got;
        hex_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind   = result_kind_t'(m_tuser);
            got.addr   = m_tdata[15:0];
            got.data   = m_tdata[23:16];
            got.rtype  = m_tdata[31:24];
            got.len    = m_tdata[39:32];
            got.status = status_t'(m_tdata[42:40]);
            results_seen++;
            if (got.kind == KIND_DATA) bytes_seen++;
            if (decoded_q.size() == 0) begin
                flag_mismatch("result transaction with none expected", '0, got);
            end else begin
                want = decoded_q.pop_front();
                if (got.kind !== want.kind || got.addr !== want.addr ||
                    got.data !== want.data || got.rtype !== want.rtype ||
                    got.len !== want.len || got.status !== want.status) begin
                    flag_mismatch("result transaction differs", want, got);
                end
            end
        end
    end

    initial begin : sink
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off && !held) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= calm || ($urandom_range(0, 99) >= 24);
        end
    end

    initial begin : stimulus
        hex_result_t want;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        line_clear();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[i]) begin
            line_buf.delete();
            for (int j = 0; j < dir_tab[i].text.len(); j++)
                append_char(dir_tab[i].text[j]);
            want = '{kind: KIND_STATUS, addr: dir_tab[i].addr, data: 8'd0,
                     rtype: dir_tab[i].rtype, len: dir_tab[i].len, status: dir_tab[i].st};
            send_line(dir_tab[i].typed, want);
        end

        while (chars_sent < ITEMS) begin
            calm = (chars_sent >= 1000 && chars_sent < 1300);
            if (chars_sent >= 500) hold_off = 1'b1;
            build_record();
            send_line(1'b0, '0);
        end
        s_tvalid <= 1'b0;
        calm = 1'b0;

        for (int n = 0; n < 20000 && decoded_q.size() != 0; n++) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (decoded_q.size() != 0) begin
            $display("%0d expected results never arrived", decoded_q.size());
            errors += decoded_q.size();
        end

        $display("%0d characters in %0d lines, %0d results checked (%0d data bytes)",
                 chars_sent, lines_sent, results_seen, bytes_seen);
        $display("line endings: ok %0d, bad start %0d, bad hex %0d,",
                 status_tally[0], status_tally[1], status_tally[2]);
        $display("    truncated %0d, checksum %0d", status_tally[3], status_tally[4]);
        if (errors == 0) begin
            $display("intel_hex_record_parser: match");
        end else begin
            $display("intel_hex_record_parser: mismatch");
        end
        $finish;
    end

    initial begin : watchdog
        #500us;
        $display("timeout with %0d results outstanding", decoded_q.size());
        $display("intel_hex_record_parser: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
design/ihex_pkg.sv
design/intel_hex_record_parser.sv
tb/sv/tb_top.sv
